// ===== rtl/trw_pkg.sv =====
package trw_pkg;

    localparam int TOKEN_W  = 32;
    localparam int WM_W     = 10;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 8;

    localparam logic [STATUS_W-1:0] STATUS_SUCCESS   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_WIN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_TOKEN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKLOG_LIMIT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_WATERMARK  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_WATERMARK = 8'd3;

    localparam logic [WM_W-1:0] BACKLOG_RESET = 10'd0;
    localparam logic [WM_W-1:0] LOW_WM_RESET  = 10'd256;
    localparam logic [WM_W-1:0] HIGH_WM_RESET = 10'd768;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_SHRINK,
        ST_BL_READ,
        ST_BL_TEST,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/token_replay_window_core.sv =====
// Anti-replay window over 32-bit tokens, serial-number order modulo 2^32.
// Input channel s_valid/s_ready/s_token: one token per item. Result channel
// m_valid/m_ready/m_status: one status per item (success, out of window,
// duplicate). Configuration: cfg_we/cfg_index/cfg_wdata, single-cycle writes;
// the user must write only while the block is idle, which it does not enforce.
// The spent bitmap is a single-port memory with a registered read, walked by
// a small sequencer. An out-of-window token goes from idle straight to the
// result; any other token is looked up and checked, and a duplicate then goes
// to the result, while a success passes the optional watermark shrink and the
// backlog step first. The shrink retires one base entry per step; the backlog
// step reads the base entry and retires it if spent, both paced by the one port.
// Only one item is in work at a time; the next is accepted as soon as the
// previous status has moved into the output register, even if the receiver
// has not taken it yet. A stalled receiver holds the status in the output
// register and the sequencer waits before loading the next one.
// After reset, and after every start_token write, the bitmap is cleared one
// entry per cycle over all WINDOW_SIZE entries, during which s_ready stays low.
module token_replay_window_core
    import trw_pkg::*;
#(
    parameter int WINDOW_SIZE = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TOKEN_W-1:0]   cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TOKEN_W-1:0]   s_token,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status
);

    localparam int DW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW = (DW > WM_W) ? DW : WM_W;
    localparam logic [DW-1:0]      LAST_SLOT = DW'(WINDOW_SIZE - 1);
    localparam logic [DW:0]        WS_SUM    = (DW+1)'(WINDOW_SIZE);
    localparam logic [TOKEN_W-1:0] WS_TOKEN  = TOKEN_W'(WINDOW_SIZE);

    logic spent_mem [WINDOW_SIZE];
    logic mem_rdata_reg;
    logic mem_we;
    logic mem_wdata;
    logic [DW-1:0] mem_addr;

    state_t state_reg, state_next;
    logic [TOKEN_W-1:0]  base_reg, base_next;
    logic [DW-1:0]       ring_reg, ring_next;
    logic [DW-1:0]       dist_reg, dist_next;
    logic [DW-1:0]       slot_reg, slot_next;
    logic [DW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [STATUS_W-1:0] pend_reg, pend_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [WM_W-1:0]     backlog_reg, low_wm_reg, high_wm_reg;

    logic [TOKEN_W-1:0] dist_in;
    logic [DW:0]        slot_sum;
    logic [DW-1:0]      slot_calc;
    logic [CW-1:0]      dist_ext;
    logic               advance;

    assign dist_in   = s_token - base_reg;
    assign slot_sum  = {1'b0, dist_reg} + {1'b0, ring_reg};
    assign slot_calc = (slot_sum >= WS_SUM) ? DW'(slot_sum - WS_SUM) : slot_sum[DW-1:0];
    assign dist_ext  = CW'(dist_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            spent_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= spent_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            backlog_reg <= BACKLOG_RESET;
            low_wm_reg  <= LOW_WM_RESET;
            high_wm_reg <= HIGH_WM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BACKLOG_LIMIT:  backlog_reg <= cfg_wdata[WM_W-1:0];
                REG_LOW_WATERMARK:  low_wm_reg  <= cfg_wdata[WM_W-1:0];
                REG_HIGH_WATERMARK: high_wm_reg <= cfg_wdata[WM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            base_reg    <= '0;
            ring_reg    <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            ring_reg    <= ring_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg     <= dist_next;
        slot_reg     <= slot_next;
        pend_reg     <= pend_next;
        m_status_reg <= m_status_next;
    end

    always_comb begin
        state_next    = state_reg;
        base_next     = base_reg;
        ring_next     = ring_reg;
        dist_next     = dist_reg;
        slot_next     = slot_reg;
        clr_cnt_next  = clr_cnt_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        m_status_next = m_status_reg;
        mem_we        = 1'b0;
        mem_wdata     = 1'b0;
        mem_addr      = ring_reg;
        s_ready       = 1'b0;
        advance       = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
                if (clr_cnt_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (dist_in >= WS_TOKEN) begin
                        pend_next  = STATUS_OUT_OF_WIN;
                        state_next = ST_RESP;
                    end else begin
                        dist_next  = dist_in[DW-1:0];
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                mem_addr   = slot_calc;
                slot_next  = slot_calc;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (mem_rdata_reg) begin
                    pend_next  = STATUS_DUPLICATE;
                    state_next = ST_RESP;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b1;
                    mem_addr  = slot_reg;
                    if (dist_ext >= CW'(high_wm_reg)) begin
                        state_next = ST_SHRINK;
                    end else begin
                        state_next = ST_BL_READ;
                    end
                end
            end
            ST_SHRINK: begin
                if (dist_ext > CW'(low_wm_reg)) begin
                    advance = 1'b1;
                end else begin
                    state_next = ST_BL_READ;
                end
            end
            ST_BL_READ: begin
                if (dist_ext > CW'(backlog_reg)) begin
                    state_next = ST_BL_TEST;
                end else begin
                    pend_next  = STATUS_SUCCESS;
                    state_next = ST_RESP;
                end
            end
            ST_BL_TEST: begin
                if (mem_rdata_reg) begin
                    advance    = 1'b1;
                    state_next = ST_BL_READ;
                end else begin
                    pend_next  = STATUS_SUCCESS;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = pend_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase

        // retire the entry at the base and slide by one
        if (advance) begin
            mem_we    = 1'b1;
            mem_wdata = 1'b0;
            mem_addr  = ring_reg;
            base_next = base_reg + 1'b1;
            ring_next = (ring_reg == LAST_SLOT) ? '0 : ring_reg + 1'b1;
            dist_next = dist_reg - 1'b1;
        end

        if (cfg_we && cfg_index == REG_START_TOKEN) begin
            base_next    = cfg_wdata;
            ring_next    = '0;
            clr_cnt_next = '0;
            state_next   = ST_CLEAR;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

endmodule
